// ----- sv/sbtr_pkg.sv -----
// ----------------------------------------------------------------------------
// sbtr_pkg - shared types, constants and helpers
// Screen size, cell geometry, fallback glyph, configuration layout and the
// job record that passes from the front end to the fill-block sequencer.
// ----------------------------------------------------------------------------
package sbtr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int CURSOR_W = 12;
  localparam int COORD_W  = 13;
  localparam int X_W      = 9;
  localparam int Y_W      = 8;
  localparam int COLOR_W  = 16;
  localparam int SCALE_W  = 5;
  localparam int PIXCNT_W = 9;
  localparam int CODE_W   = 8;
  localparam int GLYPH_W  = 40;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int CELL_COLS = 6;
  localparam int CELL_ROWS = 8;
  localparam int LINE_GAP  = 2;
  localparam int MAX_SCALE = 16;

  localparam logic [COORD_W-1:0]  SCR_W      = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0]  SCR_H      = COORD_W'(SCREEN_HEIGHT);
  localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

  localparam logic [2:0] LAST_COL = 3'(CELL_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(CELL_ROWS - 1);

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0] PRINT_LO     = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_HI     = 8'd126;

  // '?' glyph, column 0 in the low byte
  localparam logic [GLYPH_W-1:0] QMARK_GLYPH = 40'h06_09_51_01_02;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_FORE_COLOR = 3'd2,
    CFG_BACK_COLOR = 3'd3,
    CFG_SCALE      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [X_W-1:0]     origin_x;
    logic [Y_W-1:0]     origin_y;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [GLYPH_W-1:0]  glyph;
    logic [CURSOR_W-1:0] col;
    logic [CURSOR_W-1:0] row;
  } job_t;

  // Clamp the scale register into 1..16
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
    logic [SCALE_W-1:0] s;
    s = raw;
    if (raw == '0) begin
      s = SCALE_W'(1);
    end else if (raw > SCALE_W'(MAX_SCALE)) begin
      s = SCALE_W'(MAX_SCALE);
    end
    return s;
  endfunction

  // Saturate a cursor sum at the cursor maximum
  function automatic logic [CURSOR_W-1:0] sat_cursor(input logic [COORD_W-1:0] sum);
    logic [CURSOR_W-1:0] r;
    r = sum[CURSOR_W-1:0];
    if (sum > {1'b0, CURSOR_MAX}) begin
      r = CURSOR_MAX;
    end
    return r;
  endfunction

endpackage

// ----- sv/scaled_bitmap_text_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// scaled_bitmap_text_rasterizer_core - scaled 5x7 text to fill rectangles
// Keeps a text cursor, expands each character into a 6x8 cell of
// scale-by-scale fill blocks and clips blocks that run off the screen.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ------------------------------
//  in        request    in_valid_i/in_stall_o   char_code, glyph_columns,
//                                               string_start
//  out       result     out_valid_o/out_stall_i rect_x0/y0/x1/y1, fill_color,
//                                               pixel_count, last_block
//  cfg       write      cfg_we_i                cfg_idx_i, cfg_data_i
//
//  Flow: one request per cycle enters while the job queue has room; the
//  sequencer gives one block per cycle unless the output stalls, up to 48
//  blocks per drawn character. Newlines and fully clipped characters use
//  the front end only. Reset: asynchronous, active low; clears cursor, queue
//  and output valid and loads register defaults. Stalls: in_stall_o rises
//  only while both queue entries wait; a taken output frees the sequencer.
// ----------------------------------------------------------------------------
module scaled_bitmap_text_rasterizer_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [sbtr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sbtr_pkg::CFG_W-1:0]            cfg_data_i,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sbtr_pkg::CODE_W-1:0]           char_code_i,
  input  logic [sbtr_pkg::GLYPH_W-1:0]          glyph_columns_i,
  input  logic                                  string_start_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sbtr_pkg::X_W-1:0]              rect_x0_o,
  output logic [sbtr_pkg::Y_W-1:0]              rect_y0_o,
  output logic [sbtr_pkg::X_W-1:0]              rect_x1_o,
  output logic [sbtr_pkg::Y_W-1:0]              rect_y1_o,
  output logic [sbtr_pkg::COLOR_W-1:0]          fill_color_o,
  output logic [sbtr_pkg::PIXCNT_W-1:0]         pixel_count_o,
  output logic                                  last_block_o
);

  sbtr_pkg::cfg_t cfg_q;
  sbtr_pkg::job_t push_job, pop_job;
  logic           push, pop, q_full, q_empty;

  // Register file: to be written only while the block is idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.fore_color <= '1;
      cfg_q.back_color <= '0;
      cfg_q.scale      <= sbtr_pkg::SCALE_W'(1);
    end else if (cfg_we_i) begin
      case (sbtr_pkg::cfg_idx_e'(cfg_idx_i))
        sbtr_pkg::CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data_i[sbtr_pkg::X_W-1:0];
        sbtr_pkg::CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data_i[sbtr_pkg::Y_W-1:0];
        sbtr_pkg::CFG_FORE_COLOR: cfg_q.fore_color <= cfg_data_i[sbtr_pkg::COLOR_W-1:0];
        sbtr_pkg::CFG_BACK_COLOR: cfg_q.back_color <= cfg_data_i[sbtr_pkg::COLOR_W-1:0];
        sbtr_pkg::CFG_SCALE:      cfg_q.scale      <= cfg_data_i[sbtr_pkg::SCALE_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Front end: cursor and classification
  sbtr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .char_code_i     (char_code_i),
    .glyph_columns_i (glyph_columns_i),
    .string_start_i  (string_start_i),
    .in_stall_o      (in_stall_o),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  // Hold up to two characters between the two halves
  sbtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (q_empty)
  );

  // Back end: one fill block per cycle into the output register unless the output stalls
  sbtr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rect_x0_o     (rect_x0_o),
    .rect_y0_o     (rect_y0_o),
    .rect_x1_o     (rect_x1_o),
    .rect_y1_o     (rect_y1_o),
    .fill_color_o  (fill_color_o),
    .pixel_count_o (pixel_count_o),
    .last_block_o  (last_block_o)
  );

endmodule

// ----- sv/sbtr_front.sv -----
// ----------------------------------------------------------------------------
// sbtr_front - request intake and text cursor
// Classifies each character, moves the cursor and queues a drawing job for
// every character that has at least one block on screen.
// ----------------------------------------------------------------------------
module sbtr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sbtr_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  input  logic [sbtr_pkg::CODE_W-1:0]          char_code_i,
  input  logic [sbtr_pkg::GLYPH_W-1:0]         glyph_columns_i,
  input  logic                                 string_start_i,
  output logic                                 in_stall_o,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output sbtr_pkg::job_t                       job_o
);

  logic [sbtr_pkg::CURSOR_W-1:0] cursor_col_q, cursor_col_d;
  logic [sbtr_pkg::CURSOR_W-1:0] cursor_row_q, cursor_row_d;
  logic [sbtr_pkg::CURSOR_W-1:0] col0, row0;
  logic [sbtr_pkg::COORD_W-1:0]  s13, nl_step, adv_step, x1, y1;
  logic                          accept, is_nl, printable, visible;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign s13      = sbtr_pkg::COORD_W'(sbtr_pkg::eff_scale(cfg_i.scale));
  assign nl_step  = s13 * sbtr_pkg::COORD_W'(sbtr_pkg::CELL_ROWS)
                  + sbtr_pkg::COORD_W'(sbtr_pkg::LINE_GAP);
  assign adv_step = s13 * sbtr_pkg::COORD_W'(sbtr_pkg::CELL_COLS);

  assign col0 = string_start_i ? sbtr_pkg::CURSOR_W'(cfg_i.origin_x) : cursor_col_q;
  assign row0 = string_start_i ? sbtr_pkg::CURSOR_W'(cfg_i.origin_y) : cursor_row_q;

  assign is_nl     = (char_code_i == sbtr_pkg::NEWLINE_CODE);
  assign printable = char_code_i inside {[sbtr_pkg::PRINT_LO:sbtr_pkg::PRINT_HI]};

  // Top-left block decides whether anything of the cell shows
  assign x1      = {1'b0, col0} + s13 - sbtr_pkg::COORD_W'(1);
  assign y1      = {1'b0, row0} + s13 - sbtr_pkg::COORD_W'(1);
  assign visible = (x1 < sbtr_pkg::SCR_W) && (y1 < sbtr_pkg::SCR_H);

  assign push_o      = accept && !is_nl && visible;
  assign job_o.glyph = printable ? glyph_columns_i : sbtr_pkg::QMARK_GLYPH;
  assign job_o.col   = col0;
  assign job_o.row   = row0;

  always_comb begin
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    if (accept) begin
      if (is_nl) begin
        cursor_col_d = sbtr_pkg::CURSOR_W'(cfg_i.origin_x);
        cursor_row_d = sbtr_pkg::sat_cursor({1'b0, row0} + nl_step);
      end else begin
        cursor_col_d = sbtr_pkg::sat_cursor({1'b0, col0} + adv_step);
        cursor_row_d = row0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= '0;
      cursor_row_q <= '0;
    end else begin
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
    end
  end

endmodule

// ----- sv/sbtr_queue.sv -----
// ----------------------------------------------------------------------------
// sbtr_queue - two-entry job queue
// Decouples the cursor front end from the block sequencer.
// ----------------------------------------------------------------------------
module sbtr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbtr_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output sbtr_pkg::job_t job_o,
  output logic           empty_o
);

  sbtr_pkg::job_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from an empty queue");

endmodule

// ----- sv/sbtr_back.sv -----
// ----------------------------------------------------------------------------
// sbtr_back - fill-block sequencer
// Walks the visible blocks of one cell column by column, top to bottom, and
// registers one fill rectangle per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sbtr_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbtr_pkg::cfg_t                      cfg_i,
  input  logic                                q_empty_i,
  input  sbtr_pkg::job_t                      job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sbtr_pkg::X_W-1:0]            rect_x0_o,
  output logic [sbtr_pkg::Y_W-1:0]            rect_y0_o,
  output logic [sbtr_pkg::X_W-1:0]            rect_x1_o,
  output logic [sbtr_pkg::Y_W-1:0]            rect_y1_o,
  output logic [sbtr_pkg::COLOR_W-1:0]        fill_color_o,
  output logic [sbtr_pkg::PIXCNT_W-1:0]       pixel_count_o,
  output logic                                last_block_o
);

  logic                                 busy_q;
  logic                                 out_valid_q;
  logic [2:0]                           c_q, r_q;
  logic [sbtr_pkg::COORD_W-1:0]         px_q, py_q, row_base_q;
  logic [sbtr_pkg::GLYPH_W-1:0]         glyph_q;

  logic [sbtr_pkg::SCALE_W-1:0]         s;
  logic [sbtr_pkg::COORD_W-1:0]         s13, x1, y1, nx1, ny1;
  logic [sbtr_pkg::CELL_COLS*8-1:0]     dot_map;
  logic                                 row_more, col_more, emit, done, take, dot;

  logic [sbtr_pkg::X_W-1:0]             x0_q, x1_q;
  logic [sbtr_pkg::Y_W-1:0]             y0_q, y1_q;
  logic [sbtr_pkg::COLOR_W-1:0]         color_q;
  logic [sbtr_pkg::PIXCNT_W-1:0]        pixcnt_q;
  logic                                 last_q;

  assign s   = sbtr_pkg::eff_scale(cfg_i.scale);
  assign s13 = sbtr_pkg::COORD_W'(s);
  assign x1  = px_q + s13 - sbtr_pkg::COORD_W'(1);
  assign y1  = py_q + s13 - sbtr_pkg::COORD_W'(1);
  assign nx1 = x1 + s13;
  assign ny1 = y1 + s13;

  // Visible blocks form a prefix in both directions
  assign row_more = (r_q != sbtr_pkg::LAST_ROW) && (ny1 < sbtr_pkg::SCR_H);
  assign col_more = (c_q != sbtr_pkg::LAST_COL) && (nx1 < sbtr_pkg::SCR_W);

  // Blank sixth column above the glyph bytes
  assign dot_map = {8'h00, glyph_q};
  assign dot     = dot_map[{c_q, r_q}];

  assign emit  = busy_q && (!out_valid_q || !out_stall_i);
  assign done  = emit && !row_more && !col_more;
  assign take  = !q_empty_i && (!busy_q || done);
  assign pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      c_q        <= 3'd0;
      r_q        <= 3'd0;
      px_q       <= sbtr_pkg::COORD_W'(job_i.col);
      py_q       <= sbtr_pkg::COORD_W'(job_i.row);
      row_base_q <= sbtr_pkg::COORD_W'(job_i.row);
      glyph_q    <= job_i.glyph;
    end else if (emit && !done) begin
      if (row_more) begin
        r_q  <= r_q + 3'd1;
        py_q <= py_q + s13;
      end else begin
        c_q  <= c_q + 3'd1;
        r_q  <= 3'd0;
        py_q <= row_base_q;
        px_q <= px_q + s13;
      end
    end
    if (emit) begin
      x0_q     <= px_q[sbtr_pkg::X_W-1:0];
      y0_q     <= py_q[sbtr_pkg::Y_W-1:0];
      x1_q     <= x1[sbtr_pkg::X_W-1:0];
      y1_q     <= y1[sbtr_pkg::Y_W-1:0];
      color_q  <= dot ? cfg_i.fore_color : cfg_i.back_color;
      pixcnt_q <= sbtr_pkg::PIXCNT_W'(s) * sbtr_pkg::PIXCNT_W'(s);
      last_q   <= !row_more && !col_more;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rect_x0_o     = x0_q;
  assign rect_y0_o     = y0_q;
  assign rect_x1_o     = x1_q;
  assign rect_y1_o     = y1_q;
  assign fill_color_o  = color_q;
  assign pixel_count_o = pixcnt_q;
  assign last_block_o  = last_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (c_q <= sbtr_pkg::LAST_COL))
    else $error("cell column counter past the blank column");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (!busy_q || $past(take)))
    else $error("sequencer still busy after its last block without a new job");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - text rasteriser testbench
// Streams characters into the rasteriser and checks every fill rectangle
// against a behavioural copy of the cursor and glyph expansion. It runs
// directed edge cases, then random text strings under several register
// settings and sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  // One fill rectangle as it leaves the block
  typedef struct packed {
    logic [sbtr_pkg::X_W-1:0]      x0;
    logic [sbtr_pkg::Y_W-1:0]      y0;
    logic [sbtr_pkg::X_W-1:0]      x1;
    logic [sbtr_pkg::Y_W-1:0]      y1;
    logic [sbtr_pkg::COLOR_W-1:0]  color;
    logic [sbtr_pkg::PIXCNT_W-1:0] pixels;
    logic                          last;
  } fill_rect_t;

  // One character request
  typedef struct packed {
    logic [sbtr_pkg::CODE_W-1:0]  code;
    logic [sbtr_pkg::GLYPH_W-1:0] glyph;
    logic                         restart;
  } char_req_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sbtr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sbtr_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [sbtr_pkg::CODE_W-1:0]    char_code_i;
  logic [sbtr_pkg::GLYPH_W-1:0]   glyph_columns_i;
  logic                           string_start_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [sbtr_pkg::X_W-1:0]       rect_x0_o;
  logic [sbtr_pkg::Y_W-1:0]       rect_y0_o;
  logic [sbtr_pkg::X_W-1:0]       rect_x1_o;
  logic [sbtr_pkg::Y_W-1:0]       rect_y1_o;
  logic [sbtr_pkg::COLOR_W-1:0]   fill_color_o;
  logic [sbtr_pkg::PIXCNT_W-1:0]  pixel_count_o;
  logic                           last_block_o;

  // Requests waiting for the driver, rectangles waiting for the block
  char_req_t  pending_chars[$];
  fill_rect_t expected_rects[$];

  // Shadow of the registers and the text cursor
  sbtr_pkg::cfg_t text_cfg;
  int             cur_col;
  int             cur_row;

  int   send_idle_pct;
  int   recv_stall_pct;
  bit   req_accepted;
  int   cycle_count;
  int   mismatch_count;

  scaled_bitmap_text_rasterizer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .glyph_columns_i (glyph_columns_i),
    .string_start_i  (string_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rect_x0_o       (rect_x0_o),
    .rect_y0_o       (rect_y0_o),
    .rect_x1_o       (rect_x1_o),
    .rect_y1_o       (rect_y1_o),
    .fill_color_o    (fill_color_o),
    .pixel_count_o   (pixel_count_o),
    .last_block_o    (last_block_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Hold the cursor at its 12-bit ceiling
  function automatic int clamp_cursor(input int sum);
    return (sum > int'(sbtr_pkg::CURSOR_MAX)) ? int'(sbtr_pkg::CURSOR_MAX) : sum;
  endfunction

  // Expand one accepted request into the rectangles it should produce and
  // advance the shadow cursor exactly as the block should.
  function automatic void expand_char(input logic [sbtr_pkg::CODE_W-1:0] code,
                                      input logic [sbtr_pkg::GLYPH_W-1:0] columns,
                                      input logic restart);
    int          step;
    int          c;
    int          r;
    int          px;
    int          py;
    int          x1;
    int          y1;
    bit          have_prev;
    bit          unprintable;
    logic [47:0] dots;
    fill_rect_t  rect;
    fill_rect_t  prev;
    // A scale of zero draws as one, anything past the maximum as the maximum
    if (text_cfg.scale == '0) begin
      step = 1;
    end else if (int'(text_cfg.scale) > sbtr_pkg::MAX_SCALE) begin
      step = sbtr_pkg::MAX_SCALE;
    end else begin
      step = int'(text_cfg.scale);
    end
    if (restart) begin
      cur_col = text_cfg.origin_x;
      cur_row = text_cfg.origin_y;
    end
    // Newline: back to the origin column, down one text line, nothing drawn
    if (code == sbtr_pkg::NEWLINE_CODE) begin
      cur_col = text_cfg.origin_x;
      cur_row = clamp_cursor(cur_row + sbtr_pkg::CELL_ROWS * step + sbtr_pkg::LINE_GAP);
      return;
    end
    // Unprintable codes fall back to the question mark; the sixth column is blank
    unprintable = (code < sbtr_pkg::PRINT_LO) || (code > sbtr_pkg::PRINT_HI);
    dots = {8'h00, unprintable ? sbtr_pkg::QMARK_GLYPH : columns};
    have_prev = 1'b0;
    prev = '0;
    for (c = 0; c < sbtr_pkg::CELL_COLS; c++) begin
      for (r = 0; r < sbtr_pkg::CELL_ROWS; r++) begin
        px = cur_col + c * step;
        py = cur_row + r * step;
        x1 = px + step - 1;
        y1 = py + step - 1;
        // Drop blocks that run past the right or bottom edge
        if (x1 < sbtr_pkg::SCREEN_WIDTH && y1 < sbtr_pkg::SCREEN_HEIGHT) begin
          rect.x0     = px[sbtr_pkg::X_W-1:0];
          rect.y0     = py[sbtr_pkg::Y_W-1:0];
          rect.x1     = x1[sbtr_pkg::X_W-1:0];
          rect.y1     = y1[sbtr_pkg::Y_W-1:0];
          rect.color  = dots[8 * c + r] ? text_cfg.fore_color : text_cfg.back_color;
          rect.pixels = sbtr_pkg::PIXCNT_W'(step * step);
          rect.last   = 1'b0;
          if (have_prev) begin
            expected_rects.push_back(prev);
          end
          prev = rect;
          have_prev = 1'b1;
        end
      end
    end
    // Flag the final visible block of the character
    if (have_prev) begin
      prev.last = 1'b1;
      expected_rects.push_back(prev);
    end
    cur_col = clamp_cursor(cur_col + sbtr_pkg::CELL_COLS * step);
  endfunction

  task automatic flag_mismatch(input string what, input bit has_want,
                               input fill_rect_t want, input fill_rect_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      if (has_want) begin
        $display("[%0t] %s: expected x0=%0d y0=%0d x1=%0d y1=%0d colour=%h px=%0d last=%b",
                 $realtime, what, want.x0, want.y0, want.x1, want.y1, want.color,
                 want.pixels, want.last);
      end else begin
        $display("[%0t] %s: nothing expected", $realtime, what);
      end
      $display("    got x0=%0d y0=%0d x1=%0d y1=%0d colour=%h px=%0d last=%b",
               got.x0, got.y0, got.x1, got.y1, got.color, got.pixels, got.last);
    end
  endtask

  // Monitor: take requests into the shadow model, check each rectangle taken,
  // and stop the run if it hangs.
  always @(posedge clk_i) begin : watch
    fill_rect_t got;
    fill_rect_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      req_accepted = rst_ni && in_valid_i && !in_stall_o;
      if (req_accepted) begin
        expand_char(char_code_i, glyph_columns_i, string_start_i);
      end
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.x0     = rect_x0_o;
        got.y0     = rect_y0_o;
        got.x1     = rect_x1_o;
        got.y1     = rect_y1_o;
        got.color  = fill_color_o;
        got.pixels = pixel_count_o;
        got.last   = last_block_o;
        if (expected_rects.size() == 0) begin
          flag_mismatch("unexpected rectangle", 1'b0, '0, got);
        end else begin
          want = expected_rects.pop_front();
          if (got !== want) begin
            flag_mismatch("rectangle mismatch", 1'b1, want, got);
          end
        end
      end
    end
  end

  // Driver: present the next request once the current one is taken, idling
  // and stalling at the rates of the current phase.
  always @(negedge clk_i) begin : drive
    char_req_t req;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_accepted) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_chars.pop_front();
        in_valid_i      <= 1'b1;
        char_code_i     <= req.code;
        glyph_columns_i <= req.glyph;
        string_start_i  <= req.restart;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  function automatic logic [sbtr_pkg::GLYPH_W-1:0] random_glyph();
    return sbtr_pkg::GLYPH_W'({$urandom, $urandom});
  endfunction

  function automatic void push_char(input logic [sbtr_pkg::CODE_W-1:0] code,
                                    input logic [sbtr_pkg::GLYPH_W-1:0] glyph,
                                    input logic restart);
    char_req_t req;
    req.code    = code;
    req.glyph   = glyph;
    req.restart = restart;
    pending_chars.push_back(req);
  endfunction

  // Mostly well-formed strings (start flag on the first character, printable
  // codes with the odd newline), with some raw noise requests mixed in.
  task automatic push_random_text(input int n_items, input int newline_pct,
                                  input int noise_pct);
    int added;
    int len;
    int i;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < noise_pct) begin
        push_char(sbtr_pkg::CODE_W'($urandom_range(255)), random_glyph(),
                  1'($urandom_range(1)));
        added++;
      end else begin
        len = $urandom_range(10, 1);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(99) < newline_pct) begin
            push_char(sbtr_pkg::NEWLINE_CODE, random_glyph(), i == 0);
          end else begin
            push_char(sbtr_pkg::CODE_W'($urandom_range(126, 32)), random_glyph(), i == 0);
          end
          added++;
        end
      end
    end
  endtask

  // Write one register while the block is idle; update the shadow copy too
  task automatic write_reg(input sbtr_pkg::cfg_idx_e idx,
                           input logic [sbtr_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      sbtr_pkg::CFG_ORIGIN_X:   text_cfg.origin_x   = value[sbtr_pkg::X_W-1:0];
      sbtr_pkg::CFG_ORIGIN_Y:   text_cfg.origin_y   = value[sbtr_pkg::Y_W-1:0];
      sbtr_pkg::CFG_FORE_COLOR: text_cfg.fore_color = value[sbtr_pkg::COLOR_W-1:0];
      sbtr_pkg::CFG_BACK_COLOR: text_cfg.back_color = value[sbtr_pkg::COLOR_W-1:0];
      sbtr_pkg::CFG_SCALE:      text_cfg.scale      = value[sbtr_pkg::SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every request is taken and every rectangle has come back, then
  // allow for silent work (newlines, fully clipped characters) still inside.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_valid_i || expected_rects.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int i;
    // Initialise every input and the shadow state to reset values
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = sbtr_pkg::CFG_ORIGIN_X;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    char_code_i     = '0;
    glyph_columns_i = '0;
    string_start_i  = 1'b0;
    out_stall_i     = 1'b0;
    req_accepted    = 1'b0;
    cycle_count     = 0;
    mismatch_count  = 0;
    text_cfg.origin_x   = '0;
    text_cfg.origin_y   = '0;
    text_cfg.fore_color = 16'hFFFF;
    text_cfg.back_color = 16'h0000;
    text_cfg.scale      = sbtr_pkg::SCALE_W'(1);
    cur_col = 0;
    cur_row = 0;

    // First mix: sender idles lightly, receiver stalls heavily
    send_idle_pct  = 34;
    recv_stall_pct = 82;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: printable bounds, unprintable codes, newlines with and
    // without the start flag, all-ones and all-zero glyphs
    push_char(sbtr_pkg::PRINT_LO, '1, 1'b1);
    push_char(sbtr_pkg::PRINT_HI, '0, 1'b0);
    push_char(8'd31, '1, 1'b0);
    push_char(8'd127, '1, 1'b0);
    push_char(8'd0, random_glyph(), 1'b0);
    push_char(8'd255, random_glyph(), 1'b1);
    push_char(sbtr_pkg::NEWLINE_CODE, '1, 1'b0);
    push_char(8'd65, 40'hAA_55_AA_55_AA, 1'b0);
    push_char(sbtr_pkg::NEWLINE_CODE, '0, 1'b1);
    push_char(8'd72, 40'h7F_08_08_08_7F, 1'b0);
    wait_idle();

    // Origin in the bottom-right corner: one visible block, then clipping
    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd319);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd239);
    push_char(8'd88, '1, 1'b1);
    push_char(8'd89, '1, 1'b0);
    push_char(sbtr_pkg::NEWLINE_CODE, '0, 1'b0);
    push_char(8'd90, '1, 1'b0);
    push_char(8'd91, '0, 1'b1);
    wait_idle();

    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd0);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd0);
    write_reg(sbtr_pkg::CFG_FORE_COLOR, 16'h0000);
    write_reg(sbtr_pkg::CFG_BACK_COLOR, 16'hFFFF);
    write_reg(sbtr_pkg::CFG_SCALE, 16'd2);
    push_random_text(30, 10, 15);
    wait_idle();

    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd100);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd50);
    write_reg(sbtr_pkg::CFG_FORE_COLOR, 16'($urandom));
    write_reg(sbtr_pkg::CFG_BACK_COLOR, 16'($urandom));
    write_reg(sbtr_pkg::CFG_SCALE, 16'd5);
    push_random_text(20, 15, 15);
    wait_idle();

    // Second mix: sender idles heavily, receiver stalls lightly
    send_idle_pct  = 82;
    recv_stall_pct = 34;
    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd0);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd0);
    write_reg(sbtr_pkg::CFG_SCALE, 16'd16);
    push_random_text(15, 10, 20);
    wait_idle();

    // Scale of zero draws as one
    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd13);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd7);
    write_reg(sbtr_pkg::CFG_FORE_COLOR, 16'($urandom));
    write_reg(sbtr_pkg::CFG_BACK_COLOR, 16'($urandom));
    write_reg(sbtr_pkg::CFG_SCALE, 16'd0);
    push_random_text(25, 10, 15);
    wait_idle();

    // Largest raw scale: run the column, then the row, into saturation; a
    // wrapping cursor would bring blocks back on screen
    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd0);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd0);
    write_reg(sbtr_pkg::CFG_SCALE, 16'd31);
    push_char(sbtr_pkg::CODE_W'($urandom_range(126, 32)), random_glyph(), 1'b1);
    for (i = 0; i < 45; i++) begin
      push_char(sbtr_pkg::CODE_W'($urandom_range(126, 32)), random_glyph(), 1'b0);
    end
    for (i = 0; i < 35; i++) begin
      push_char(sbtr_pkg::NEWLINE_CODE, random_glyph(), 1'b0);
    end
    for (i = 0; i < 3; i++) begin
      push_char(sbtr_pkg::CODE_W'($urandom_range(255)), random_glyph(), 1'b0);
    end
    wait_idle();

    // Third mix: no idling on either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'($urandom_range(319)));
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'($urandom_range(239)));
    write_reg(sbtr_pkg::CFG_SCALE, 16'd3);
    push_random_text(25, 10, 15);
    wait_idle();

    write_reg(sbtr_pkg::CFG_ORIGIN_X, 16'd0);
    write_reg(sbtr_pkg::CFG_ORIGIN_Y, 16'd0);
    write_reg(sbtr_pkg::CFG_SCALE, 16'd17);
    push_random_text(10, 10, 20);
    wait_idle();

    write_reg(sbtr_pkg::CFG_FORE_COLOR, 16'hFFFF);
    write_reg(sbtr_pkg::CFG_BACK_COLOR, 16'($urandom));
    write_reg(sbtr_pkg::CFG_SCALE, 16'd1);
    push_random_text(25, 10, 25);
    wait_idle();

    // Anything still queued here was never produced
    mismatch_count += expected_rects.size();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sbtr_pkg.sv
sv/sbtr_front.sv
sv/sbtr_queue.sv
sv/sbtr_back.sv
sv/scaled_bitmap_text_rasterizer_core.sv
tb/tb.sv
